// ===== src/lxbt_pkg.sv =====
// ----------------------------------------------------------------------------
// lxbt_pkg: shared definitions for the lagged-XOR byte-table generator
// Item kinds, store geometry, lag constants and the fixed shuffled seed ROM.
// ----------------------------------------------------------------------------
package lxbt_pkg;

  localparam int TABLE_ENTRIES = 256;
  localparam int STORE_BYTES   = TABLE_ENTRIES + 4;
  localparam int POS_W         = $clog2(TABLE_ENTRIES);
  localparam int IDX_W         = $clog2(STORE_BYTES);
  localparam int WORD_BYTES    = 4;

  localparam logic [POS_W-1:0] READ_LAG  = POS_W'(4 * 53);
  localparam logic [POS_W-1:0] WRITE_LAG = POS_W'(WORD_BYTES);

  typedef enum logic [1:0] {
    KIND_UNSIGNED = 2'd0,
    KIND_SIGNED   = 2'd1,
    KIND_BOOL     = 2'd2,
    KIND_RESEED   = 2'd3
  } kind_t;

  localparam logic [7:0] CHAOS_ROM [TABLE_ENTRIES] = '{
    8'd198, 8'd126, 8'd129, 8'd107, 8'd75,  8'd251, 8'd226, 8'd251,
    8'd84,  8'd246, 8'd189, 8'd223, 8'd124, 8'd28,  8'd225, 8'd135,
    8'd1,   8'd191, 8'd49,  8'd222, 8'd86,  8'd114, 8'd15,  8'd71,
    8'd103, 8'd102, 8'd135, 8'd89,  8'd170, 8'd136, 8'd60,  8'd89,
    8'd234, 8'd86,  8'd19,  8'd123, 8'd210, 8'd133, 8'd161, 8'd216,
    8'd60,  8'd84,  8'd85,  8'd47,  8'd55,  8'd174, 8'd101, 8'd91,
    8'd218, 8'd2,   8'd121, 8'd152, 8'd204, 8'd227, 8'd26,  8'd118,
    8'd142, 8'd95,  8'd217, 8'd153, 8'd143, 8'd31,  8'd63,  8'd54,
    8'd238, 8'd67,  8'd120, 8'd77,  8'd13,  8'd250, 8'd190, 8'd166,
    8'd218, 8'd228, 8'd134, 8'd142, 8'd220, 8'd41,  8'd109, 8'd78,
    8'd255, 8'd86,  8'd225, 8'd112, 8'd32,  8'd251, 8'd143, 8'd177,
    8'd88,  8'd5,   8'd144, 8'd197, 8'd9,   8'd220, 8'd83,  8'd205,
    8'd170, 8'd59,  8'd72,  8'd153, 8'd82,  8'd211, 8'd82,  8'd157,
    8'd6,   8'd159, 8'd234, 8'd181, 8'd194, 8'd6,   8'd19,  8'd152,
    8'd73,  8'd178, 8'd1,   8'd30,  8'd172, 8'd50,  8'd136, 8'd49,
    8'd156, 8'd82,  8'd70,  8'd149, 8'd113, 8'd54,  8'd143, 8'd87,
    8'd246, 8'd57,  8'd29,  8'd22,  8'd250, 8'd136, 8'd116, 8'd245,
    8'd152, 8'd124, 8'd23,  8'd92,  8'd65,  8'd187, 8'd109, 8'd113,
    8'd142, 8'd15,  8'd112, 8'd89,  8'd199, 8'd1,   8'd27,  8'd47,
    8'd51,  8'd61,  8'd145, 8'd192, 8'd29,  8'd165, 8'd13,  8'd13,
    8'd171, 8'd51,  8'd141, 8'd126, 8'd94,  8'd143, 8'd62,  8'd230,
    8'd104, 8'd116, 8'd166, 8'd58,  8'd177, 8'd195, 8'd147, 8'd17,
    8'd168, 8'd100, 8'd199, 8'd219, 8'd202, 8'd224, 8'd96,  8'd225,
    8'd243, 8'd191, 8'd9,   8'd0,   8'd103, 8'd162, 8'd227, 8'd37,
    8'd160, 8'd33,  8'd49,  8'd135, 8'd213, 8'd98,  8'd197, 8'd168,
    8'd79,  8'd126, 8'd46,  8'd9,   8'd107, 8'd148, 8'd159, 8'd176,
    8'd109, 8'd169, 8'd158, 8'd90,  8'd11,  8'd70,  8'd112, 8'd128,
    8'd182, 8'd207, 8'd71,  8'd12,  8'd166, 8'd165, 8'd42,  8'd216,
    8'd172, 8'd251, 8'd160, 8'd235, 8'd183, 8'd121, 8'd36,  8'd114,
    8'd35,  8'd146, 8'd72,  8'd128, 8'd197, 8'd166, 8'd167, 8'd133,
    8'd183, 8'd215, 8'd140, 8'd144, 8'd228, 8'd171, 8'd99,  8'd68,
    8'd82,  8'd102, 8'd227, 8'd156, 8'd51,  8'd37,  8'd249, 8'd94
  };

endpackage

// ===== src/lagged_xor_byte_table_prng_top.sv =====
// ----------------------------------------------------------------------------
// lagged_xor_byte_table_prng_top: lagged-XOR byte-table random generator
// A 260-byte store and an 8-bit position. Reseed fills the store from a
// shuffled ROM; a draw reads a lagged word, XORs it into the store, and
// returns the top bits of that word in unsigned, signed or bool form.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_ready  kind, bits, seed
//  out      out_valid / out_ready random_value, signed_value, bool_value
//
//  A draw reads and writes back one byte lane of the store per cycle, 4
//  bytes in all, behind a registered memory read; the result is then formed
//  in the finish state, which waits until the output register is free.
//  A reseed writes one store byte per cycle, all 260 bytes of the store.
//  Reset clears the position and the handshakes; the store holds garbage
//  until the first reseed. in_ready drops while an item is in work and while
//  a finished result waits behind a stalled output.
// ----------------------------------------------------------------------------
module lagged_xor_byte_table_prng_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [5:0]         bits,
  input  logic [7:0]         seed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        random_value,
  output logic signed [31:0] signed_value,
  output logic               bool_value
);
  import lxbt_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SEED   = 4'b0010,
    ST_XOR    = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t             state;
  logic [IDX_W-1:0]   cnt;
  logic [POS_W-1:0]   pos;
  logic [POS_W-1:0]   rd_base;
  logic [POS_W-1:0]   wr_base;
  logic [POS_W-1:0]   seed_q;
  kind_t              kind_q;
  logic [5:0]         bits_q;
  logic [31:0]        word;

  logic [7:0]         mem [STORE_BYTES];
  logic [7:0]         rd_data;
  logic [7:0]         wr_data;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_wa;
  logic [IDX_W-1:0]   mem_ra;
  logic [IDX_W-1:0]   mem_rb;
  logic [7:0]         mem_wd;
  logic [1:0]         lane_rd;
  logic [1:0]         lane_wr;

  logic               in_fire;
  logic               out_free;
  logic [5:0]         n_u;
  logic [5:0]         n_s;
  logic [31:0]        u_res;
  logic [31:0]        s_res;
  logic               b_res;

  assign in_ready = (state == ST_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  assign lane_rd = cnt[1:0];
  assign lane_wr = 2'(cnt[2:0] - 3'd1);

  // Store ports: reseed writes byte cnt; a draw writes lane cnt-1 of the
  // write word while reading lane cnt of both words.
  always_comb begin
    mem_ra = IDX_W'(rd_base) + IDX_W'(lane_rd);
    mem_rb = IDX_W'(wr_base) + IDX_W'(lane_rd);
    mem_we = 1'b0;
    mem_wa = cnt;
    mem_wd = CHAOS_ROM[POS_W'(seed_q + cnt[POS_W-1:0])];
    if (state == ST_SEED) begin
      mem_we = 1'b1;
    end else if (state == ST_XOR && cnt != '0) begin
      mem_we = 1'b1;
      mem_wa = IDX_W'(wr_base) + IDX_W'(lane_wr);
      mem_wd = rd_data ^ wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[mem_ra];
    wr_data <= mem[mem_rb];
  end

  // Result shaping from the drawn word
  always_comb begin
    n_u = (bits_q > 6'd32) ? 6'd32 : bits_q;
    n_s = (bits_q > 6'd31) ? 6'd31 : bits_q;
    u_res = (n_u == 6'd0) ? 32'd0 : (word >> (6'd32 - n_u));
    s_res = (word >> (6'd31 - n_s)) - (32'd1 << n_s);
    b_res = !word[31];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      pos       <= '0;
      out_valid <= 1'b0;
      cnt       <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            kind_q  <= kind_t'(kind);
            bits_q  <= bits;
            cnt     <= '0;
            rd_base <= pos + READ_LAG;
            wr_base <= pos + WRITE_LAG;
            if (kind_t'(kind) == KIND_RESEED) begin
              seed_q <= seed;
              pos    <= seed;
              state  <= ST_SEED;
            end else begin
              state <= ST_XOR;
            end
          end
        end
        ST_SEED: begin
          cnt <= cnt + IDX_W'(1);
          if (cnt == IDX_W'(STORE_BYTES - 1)) begin
            state <= ST_FINISH;
          end
        end
        ST_XOR: begin
          if (cnt != '0) begin
            word[8*lane_wr +: 8] <= rd_data;
          end
          cnt <= cnt + IDX_W'(1);
          if (cnt == IDX_W'(WORD_BYTES)) begin
            pos   <= wr_base;
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // Hold until the output register is free
          if (out_free) begin
            out_valid    <= 1'b1;
            random_value <= (kind_q == KIND_UNSIGNED) ? u_res : 32'd0;
            signed_value <= (kind_q == KIND_SIGNED) ? s_res : 32'd0;
            bool_value   <= (kind_q == KIND_BOOL) ? b_res : 1'b0;
            state        <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
